[design/gpip_pkg.sv]
package gpip_pkg;

	localparam int MAX_VERTICES = 4;

	localparam int LAT_W = 31;
	localparam int LON_W = 32;
	localparam int DX_W = LAT_W + 1;
	localparam int DY_W = LON_W + 1;
	localparam int CIN_W = DY_W;
	localparam int CXY_W = CIN_W + 3;
	localparam int ANG_W = 26;
	localparam int CORDIC_STEPS = 23;
	localparam int STEP_W = $clog2(CORDIC_STEPS);

	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int NREG = 2 * MAX_VERTICES;
	localparam int REGIDX_W = $clog2(NREG);
	localparam int PADDR_W = REGIDX_W + 2;

	localparam int DEG_Q16 = 65536;
	localparam longint SumMax = longint'(MAX_VERTICES) * 180 * DEG_Q16;
	localparam int SUM_W = $clog2(SumMax + 1);
	localparam int EDGE_W = $clog2(180 * DEG_Q16 + 1);

	typedef logic signed [LAT_W-1:0] lat_t;
	typedef logic signed [LON_W-1:0] lon_t;
	typedef logic signed [CIN_W-1:0] cin_t;
	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [EDGE_W-1:0] edge_t;

	localparam lat_t LAT_LIMIT = -31'sd900000000;
	localparam lon_t LON_LIMIT = -32'sd1800000000;
	localparam lat_t VLAT_RESET = -31'sd910000000;
	localparam lon_t VLON_RESET = -32'sd1810000000;

	localparam ang_t ANG_P90 = ANG_W'(90 * DEG_Q16);
	localparam ang_t ANG_M90 = -ANG_W'(90 * DEG_Q16);
	localparam sum_t SUM_LO = SUM_W'(355 * DEG_Q16);
	localparam sum_t SUM_HI = SUM_W'(365 * DEG_Q16);

	function automatic ang_t atan_q16(input logic [STEP_W-1:0] i);
		case (i)
			5'd0: return ANG_W'(2949120);
			5'd1: return ANG_W'(1740967);
			5'd2: return ANG_W'(919879);
			5'd3: return ANG_W'(466945);
			5'd4: return ANG_W'(234379);
			5'd5: return ANG_W'(117304);
			5'd6: return ANG_W'(58666);
			5'd7: return ANG_W'(29335);
			5'd8: return ANG_W'(14668);
			5'd9: return ANG_W'(7334);
			5'd10: return ANG_W'(3667);
			5'd11: return ANG_W'(1833);
			5'd12: return ANG_W'(917);
			5'd13: return ANG_W'(458);
			5'd14: return ANG_W'(229);
			5'd15: return ANG_W'(115);
			5'd16: return ANG_W'(57);
			5'd17: return ANG_W'(29);
			5'd18: return ANG_W'(14);
			5'd19: return ANG_W'(7);
			5'd20: return ANG_W'(4);
			5'd21: return ANG_W'(2);
			5'd22: return ANG_W'(1);
			default: return '0;
		endcase
	endfunction

	// Unsigned angle between two directions, wrapped into [-180, 180] first.
	function automatic edge_t edge_angle(input ang_t from_a, input ang_t to_b);
		logic signed [ANG_W:0] d;
		d = (ANG_W+1)'(to_b) - (ANG_W+1)'(from_a);
		if (d > (ANG_W+1)'(180 * DEG_Q16))
			d = d - (ANG_W+1)'(360 * DEG_Q16);
		else if (d < -(ANG_W+1)'(180 * DEG_Q16))
			d = d + (ANG_W+1)'(360 * DEG_Q16);
		if (d < 0)
			d = -d;
		return EDGE_W'(d);
	endfunction

endpackage

[design/gpip_fix_if.sv]
interface gpip_fix_if import gpip_pkg::*; ();
	logic valid;
	logic ready;
	lat_t fix_latitude;
	lon_t fix_longitude;

	modport source(output valid, output fix_latitude, output fix_longitude, input ready);
	modport sink(input valid, input fix_latitude, input fix_longitude, output ready);
endinterface

[design/gpip_res_if.sv]
interface gpip_res_if ();
	logic valid;
	logic ready;
	logic in_fence;
	logic [2:0] vertices_used;

	modport source(output valid, output in_fence, output vertices_used, input ready);
	modport sink(input valid, input in_fence, input vertices_used, output ready);
endinterface

[design/gpip_cordic.sv]
// Vectoring CORDIC: one micro-rotation per cycle, direction in degrees Q16.
module gpip_cordic import gpip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cin_t x_in,
	input  cin_t y_in,
	output logic done,
	output ang_t angle
);

	logic signed [CXY_W-1:0] x_q, y_q, xs, ys, xe, ye;
	ang_t z_q;
	logic [STEP_W-1:0] i_q;
	logic busy_q;
	logic done_q;

	assign xe = CXY_W'(x_in);
	assign ye = CXY_W'(y_in);
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				if (i_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// Move the vector into the right half plane first.
			if (xe < 0) begin
				if (ye >= 0) begin
					x_q <= ye;
					y_q <= -xe;
					z_q <= ANG_P90;
				end else begin
					x_q <= -ye;
					y_q <= xe;
					z_q <= ANG_M90;
				end
			end else begin
				x_q <= xe;
				y_q <= ye;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_q16(i_q);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_q16(i_q);
			end
		end
	end

	assign done = done_q;
	assign angle = z_q;

endmodule

[design/geofence_point_in_polygon_unit.sv]
// Channel   Direction  Payload                          Transaction when
// fix       in         fix_latitude, fix_longitude      fix.valid && fix.ready
// res       out        in_fence, vertices_used          res.valid && res.ready
// apb       in         vertex registers at 4*index      psel && penable && pwrite
//
// For each fence vertex a fix passes S_LOAD, which loads the vertex, and S_ROT, which
// waits on the CORDIC. Then S_LOAD finds the fence end, S_CLOSE adds the closing edge
// and S_FINISH posts the result; an empty fence goes from S_LOAD straight to S_FINISH.
// A single CORDIC unit is reused for every vertex in turn.
// fix.ready is high only while idle, and a result not yet taken holds back the next one.
// Reset (arst_n low) clears the control state and sets every vertex to the end mark.
module geofence_point_in_polygon_unit import gpip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	gpip_fix_if.sink fix,
	gpip_res_if.source res,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_ROT = 3'd2;
	localparam logic [2:0] S_CLOSE = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0] state_q;

	// Fence vertex registers, written through the configuration port.
	lat_t vlat_q [MAX_VERTICES];
	lon_t vlon_q [MAX_VERTICES];

	logic [REGIDX_W-1:0] reg_idx;
	logic cfg_wr;

	assign pready = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_VERTICES; k++) begin
				vlat_q[k] <= VLAT_RESET;
				vlon_q[k] <= VLON_RESET;
			end
		end else if (cfg_wr && (int'(reg_idx) < NREG)) begin
			if (reg_idx[0])
				vlon_q[reg_idx[REGIDX_W-1:1]] <= pwdata;
			else
				vlat_q[reg_idx[REGIDX_W-1:1]] <= pwdata[LAT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (int'(reg_idx) < NREG) begin
			if (reg_idx[0])
				prdata = vlon_q[reg_idx[REGIDX_W-1:1]];
			else
				prdata = 32'(vlat_q[reg_idx[REGIDX_W-1:1]]);
		end
	end

	// The point under test and the running state of one transaction.
	lat_t lat_q;
	lon_t lon_q;
	logic [CNT_W-1:0] k_q;
	logic degen_q;
	sum_t sum_q;
	ang_t first_q;
	ang_t prev_q;

	logic res_valid_q;
	logic in_fence_q;
	logic [2:0] used_q;

	lat_t cur_lat;
	lon_t cur_lon;
	logic at_end;
	logic signed [DX_W-1:0] dx;
	logic signed [DY_W-1:0] dy;
	logic cord_start;
	logic cord_done;
	ang_t cord_angle;
	logic out_free;
	logic fence_hit;

	assign cur_lat = vlat_q[k_q[IDX_W-1:0]];
	assign cur_lon = vlon_q[k_q[IDX_W-1:0]];
	assign at_end = (k_q == CNT_W'(MAX_VERTICES)) || (cur_lat < LAT_LIMIT) ||
			(cur_lon < LON_LIMIT);
	assign dx = DX_W'(cur_lat) - DX_W'(lat_q);
	assign dy = DY_W'(cur_lon) - DY_W'(lon_q);
	assign cord_start = (state_q == S_LOAD) && !at_end;

	gpip_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cord_start),
		.x_in(CIN_W'(dx)),
		.y_in(dy),
		.done(cord_done),
		.angle(cord_angle)
	);

	assign out_free = !res_valid_q || res.ready;
	assign fence_hit = !degen_q && (k_q != '0) && (sum_q > SUM_LO) && (sum_q < SUM_HI);

	assign fix.ready = (state_q == S_IDLE);
	assign res.valid = res_valid_q;
	assign res.in_fence = in_fence_q;
	assign res.vertices_used = used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_valid_q <= 1'b0;
			k_q <= '0;
		end else begin
			// A new result may replace the one taken in the same cycle.
			if (state_q == S_FINISH && out_free)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (fix.valid) begin
						k_q <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (at_end)
						state_q <= (k_q == '0) ? S_FINISH : S_CLOSE;
					else
						state_q <= S_ROT;
				end
				S_ROT: begin
					if (cord_done) begin
						k_q <= k_q + 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_CLOSE: state_q <= S_FINISH;
				S_FINISH: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers: edges are summed as each direction arrives, and the
	// closing edge from the last vertex back to the first is added at the end.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && fix.valid) begin
			lat_q <= fix.fix_latitude;
			lon_q <= fix.fix_longitude;
			degen_q <= 1'b0;
			sum_q <= '0;
		end
		if (cord_start && dx == '0 && dy == '0)
			degen_q <= 1'b1;
		if (state_q == S_ROT && cord_done) begin
			prev_q <= cord_angle;
			if (k_q == '0)
				first_q <= cord_angle;
			else
				sum_q <= sum_q + SUM_W'(edge_angle(prev_q, cord_angle));
		end
		if (state_q == S_CLOSE)
			sum_q <= sum_q + SUM_W'(edge_angle(prev_q, first_q));
		if (state_q == S_FINISH && out_free) begin
			in_fence_q <= fence_hit;
			used_q <= 3'(k_q);
		end
	end

	a_ready_drops: assert property (@(posedge clk) disable iff (!arst_n)
		fix.valid && fix.ready |=> !fix.ready)
		else $error("fix accepted but block still ready");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex counter past fence size");

	a_cordic_owner: assert property (@(posedge clk) disable iff (!arst_n)
		cord_done |-> state_q == S_ROT)
		else $error("CORDIC finished outside its state");

	a_inside_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.in_fence |-> res.vertices_used != 3'd0)
		else $error("inside reported for an empty fence");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.in_fence))
		else $error("result changed while stalled");

endmodule

[dv/geofence_point_in_polygon_checker.sv]
module geofence_point_in_polygon_checker import gpip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	gpip_fix_if fix,
	gpip_res_if res,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic in_fence;
		logic [2:0] vertices_used;
	} verdict_t;

	localparam longint ATAN_Q16 [CORDIC_STEPS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
	};

	longint fence_lat [MAX_VERTICES];
	longint fence_lon [MAX_VERTICES];
	verdict_t verdicts_due [$];

	// Direction of (x, y) in degrees Q16 by CORDIC vectoring.
	function automatic longint heading(longint x, longint y);
		longint z, t, xs, ys;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = 90 * DEG_Q16;
			end else begin
				t = x; x = -y; y = t; z = -90 * DEG_Q16;
			end
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; z += ATAN_Q16[i];
			end else begin
				x -= ys; y += xs; z -= ATAN_Q16[i];
			end
		end
		return z;
	endfunction

	function automatic verdict_t judge_fix(lat_t lat, lon_t lon);
		longint dir [MAX_VERTICES];
		longint dx, dy, d, sum;
		int count, nxt;
		bit on_vertex;
		verdict_t v;
		count = 0;
		on_vertex = 0;
		sum = 0;
		for (int k = 0; k < MAX_VERTICES; k++) begin
			if (fence_lat[k] < longint'(LAT_LIMIT) || fence_lon[k] < longint'(LON_LIMIT))
				break;
			dx = fence_lat[k] - longint'(lat);
			dy = fence_lon[k] - longint'(lon);
			if (dx == 0 && dy == 0)
				on_vertex = 1;
			dir[k] = heading(dx, dy);
			count++;
		end
		for (int k = 0; k < count; k++) begin
			nxt = (k + 1 < count) ? k + 1 : 0;
			d = dir[nxt] - dir[k];
			if (d > 180 * DEG_Q16)
				d -= 360 * DEG_Q16;
			else if (d < -180 * DEG_Q16)
				d += 360 * DEG_Q16;
			if (d < 0)
				d = -d;
			sum += d;
		end
		v.in_fence = !on_vertex && count > 0 && sum > 355 * longint'(DEG_Q16)
			&& sum < 365 * longint'(DEG_Q16);
		v.vertices_used = 3'(count);
		return v;
	endfunction

	assign pending = verdicts_due.size();

	initial begin
		errors = 0;
		for (int k = 0; k < MAX_VERTICES; k++) begin
			fence_lat[k] = longint'(VLAT_RESET);
			fence_lon[k] = longint'(VLON_RESET);
		end
	end

	always @(posedge clk) begin
		verdict_t got, want;
		int k;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				k = int'(paddr >> 2) >> 1;
				if (paddr[2])
					fence_lon[k] = longint'(lon_t'(pwdata));
				else
					fence_lat[k] = longint'(lat_t'(pwdata[LAT_W-1:0]));
			end
			if (fix.valid && fix.ready)
				verdicts_due.push_back(judge_fix(fix.fix_latitude, fix.fix_longitude));
			if (res.valid && res.ready) begin
				got.in_fence = res.in_fence;
				got.vertices_used = res.vertices_used;
				if (verdicts_due.size() == 0) begin
					$display("%0t: unexpected result in_fence=%0b vertices_used=%0d",
						$time, got.in_fence, got.vertices_used);
					errors++;
				end else begin
					want = verdicts_due.pop_front();
					if (got.in_fence !== want.in_fence) begin
						$display("%0t: in_fence expected %0b actual %0b",
							$time, want.in_fence, got.in_fence);
						errors++;
					end
					if (got.vertices_used !== want.vertices_used) begin
						$display("%0t: vertices_used expected %0d actual %0d",
							$time, want.vertices_used, got.vertices_used);
						errors++;
					end
				end
			end
		end
	end
endmodule

[dv/geofence_point_in_polygon_unit_tb.sv]
module geofence_point_in_polygon_unit_tb;
	import gpip_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 150;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	int errors, pending;
	int idle_cycles = 0;

	// Shadow of the fence as written, used only to aim fixes near it.
	longint shadow_lat [MAX_VERTICES];
	longint shadow_lon [MAX_VERTICES];

	gpip_fix_if fix_ch ();
	gpip_res_if res_ch ();

	geofence_point_in_polygon_unit dut (
		.clk(clk), .arst_n(arst_n), .fix(fix_ch.sink), .res(res_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	geofence_point_in_polygon_checker checker_i (
		.clk(clk), .arst_n(arst_n), .fix(fix_ch), .res(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
	);

	always #5 clk = ~clk;

	initial begin
		fix_ch.valid = 0;
		fix_ch.fix_latitude = '0;
		fix_ch.fix_longitude = '0;
		res_ch.ready = 0;
	end

	// Gaps are random: often there is none, and now and then a long one.
	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		if ($urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 2);
	endfunction

	// The result side stalls at random, with stretches of steady readiness.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 1)) begin
				res_ch.ready = 1;
				repeat ($urandom_range(1, 30)) @(negedge clk);
			end
			stall = gap_len();
			if (stall > 0) begin
				res_ch.ready = 0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready = 1;
		end
	end

	// The watchdog ends the run when no transaction happens for too long.
	always @(posedge clk) begin
		if ((fix_ch.valid && fix_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic reg_write(int index, logic [31:0] value);
		@(negedge clk);
		psel = 1; penable = 0; pwrite = 1;
		paddr = PADDR_W'(index * 4);
		pwdata = value;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
	endtask

	// A vertex write touches both of its registers and the shadow copy.
	task automatic set_vertex(int k, longint lat, longint lon);
		reg_write(2 * k, 32'(lat));
		reg_write(2 * k + 1, 32'(lon));
		shadow_lat[k] = longint'(lat_t'(lat));
		shadow_lon[k] = longint'(lon_t'(lon));
	endtask

	// Registers change only when the block is idle: every result is in, and
	// the block has had time to finish anything still under way. The fix
	// channel is dropped first so that the last fix is not taken twice.
	task automatic wait_idle();
		fix_ch.valid = 0;
		while (pending != 0 || fix_ch.valid) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_fix(longint lat, longint lon);
		int gap;
		gap = gap_len();
		repeat (gap) @(negedge clk);
		if (gap > 0 || !fix_ch.valid)
			@(negedge clk);
		fix_ch.valid = 1;
		fix_ch.fix_latitude = lat_t'(lat);
		fix_ch.fix_longitude = lon_t'(lon);
		@(posedge clk);
		while (!fix_ch.ready) @(posedge clk);
		@(negedge clk);
		if ($urandom_range(0, 3) != 0 || gap > 0)
			fix_ch.valid = 0;
	endtask

	// Build a random fence of n vertices around a center, marking the rest.
	task automatic random_fence(int n);
		longint clat, clon, r;
		r = longint'(1) << $urandom_range(4, 28);
		clat = $signed($urandom_range(0, 1600000000)) - 800000000;
		clon = $signed($urandom_range(0, 3400000000)) - 1700000000;
		for (int k = 0; k < MAX_VERTICES; k++) begin
			if (k < n) begin
				// Walk the corners of a rough square so the fence is convex.
				set_vertex(k,
					clat + ((k == 0 || k == 3) ? r : -r) + $urandom_range(0, 7),
					clon + ((k < 2) ? r : -r) - $urandom_range(0, 7));
			end else if ($urandom_range(0, 2) == 0) begin
				// An end mark by longitude only: its latitude is valid, but the vertex must be ignored.
				set_vertex(k, clat, -1810000000 - $urandom_range(0, 1000));
			end else begin
				set_vertex(k, -910000000 - $urandom_range(0, 1000), $urandom());
			end
		end
	endtask

	task automatic random_fix(int n);
		int kind, k;
		longint lat, lon, r;
		kind = $urandom_range(0, 9);
		if (n == 0 || kind == 0) begin
			send_fix($urandom(), $urandom());
			return;
		end
		k = $urandom_range(0, n - 1);
		if (kind == 1) begin
			send_fix(shadow_lat[k], shadow_lon[k]);
		end else if (kind == 2) begin
			send_fix((shadow_lat[k] + shadow_lat[(k + 1) % n]) / 2,
				(shadow_lon[k] + shadow_lon[(k + 1) % n]) / 2);
		end else begin
			lat = 0; lon = 0;
			for (int j = 0; j < n; j++) begin
				lat += shadow_lat[j];
				lon += shadow_lon[j];
			end
			lat /= n; lon /= n;
			r = (shadow_lat[0] - lat);
			if (r < 0) r = -r;
			r = r + 1;
			send_fix(lat + $signed($urandom_range(0, 2 * r)) - r,
				lon + $signed($urandom_range(0, 2 * r)) - r);
		end
	endtask

	initial begin
		int n;
		for (int k = 0; k < MAX_VERTICES; k++) begin
			shadow_lat[k] = longint'(VLAT_RESET);
			shadow_lon[k] = longint'(VLON_RESET);
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Empty fence straight out of reset, with the fix fields at their limits.
		send_fix(900000000, 1800000000);
		send_fix(-900000000, -1800000000);
		send_fix(32'h3fff_ffff, 32'h7fff_ffff);
		send_fix(32'h4000_0000, 32'h8000_0000);
		wait_idle();

		// The largest rectangle the coordinate ranges allow.
		set_vertex(0, 900000000, 1800000000);
		set_vertex(1, -900000000, 1800000000);
		set_vertex(2, -900000000, -1800000000);
		set_vertex(3, 900000000, -1800000000);
		send_fix(0, 0);
		send_fix(900000000, 1800000000);
		send_fix(-900000000, -1800000000);
		send_fix(900000000, 0);
		send_fix(899999999, 1799999999);
		send_fix(-900000000, 1800000000);
		wait_idle();

		// A single vertex, and then two vertices with a fix on the segment.
		set_vertex(0, 100000000, 200000000);
		set_vertex(1, -910000000, 0);
		send_fix(0, 0);
		send_fix(100000000, 200000000);
		wait_idle();
		set_vertex(1, -100000000, -200000000);
		set_vertex(2, 0, -1810000000);
		send_fix(0, 0);
		send_fix(50000000, 100000000);
		send_fix(1, 0);
		send_fix(-100000000, -200000000);
		wait_idle();

		// Registers written with values outside the documented ranges.
		set_vertex(0, 32'h3fff_ffff, 32'h7fff_ffff);
		set_vertex(1, 32'hffff_ffff, 32'h0000_0000);
		set_vertex(2, 32'h0000_0001, 32'h0000_0001);
		set_vertex(3, 32'h8000_0000, 32'h7fff_fff0);
		send_fix(0, 0);
		send_fix(1, 1);
		send_fix(32'h3fff_ffff, 32'h8000_0000);
		wait_idle();

		// Random phases: a new fence, then a run of fixes aimed at it.
		for (int phase = 0; phase < 12; phase++) begin
			n = (phase % 6 == 0) ? $urandom_range(0, 2) : $urandom_range(3, MAX_VERTICES);
			random_fence(n);
			repeat (45) random_fix(n);
			wait_idle();
		end

		// Back to the reset state of the fence to close the run.
		for (int k = 0; k < MAX_VERTICES; k++)
			set_vertex(k, -910000000, -1810000000);
		send_fix($urandom(), $urandom());

		@(negedge clk);
		fix_ch.valid = 0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

[geofence_point_in_polygon_unit.f]
design/gpip_pkg.sv
design/gpip_fix_if.sv
design/gpip_res_if.sv
design/gpip_cordic.sv
design/geofence_point_in_polygon_unit.sv
dv/geofence_point_in_polygon_checker.sv
dv/geofence_point_in_polygon_unit_tb.sv
